>>> rtl/sha256_byte_stream_hasher_assert.svh
// Assertion macros shared by the hasher RTL.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SBSH_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define SBSH_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SBSH_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sbsh_pkg.sv
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
package sbsh_pkg;

	localparam logic MODE_ABSORB = 1'b0;
	localparam logic MODE_FINISH = 1'b1;

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] FILL_LAST = 6'd63;
	localparam logic [5:0] FILL_EMPTY = 6'd0;
	localparam logic [5:0] FILL_LEN = 6'd56;
	localparam logic [5:0] ROUND_LAST = 6'd63;
	localparam logic [2:0] WORD_LAST = 3'd7;

	localparam logic [31:0] ROUND_K [0:63] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] HASH_IV [0:7] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD_ZERO,
		ST_PAD_LEN,
		ST_LOAD,
		ST_ROUND,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SRC_DATA,
		SRC_MARK,
		SRC_ZERO,
		SRC_LEN
	} wr_src_t;

	typedef struct packed {
		logic        wr_en;
		wr_src_t     wr_src;
		logic        bits_inc;
		logic        load_v;
		logic        round_en;
		logic [5:0]  round_idx;
		logic        add_h;
		logic        init;
		logic [2:0]  word_sel;
	} cmd_t;

	typedef struct packed {
		logic [5:0] fill;
	} status_t;

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

>>> rtl/sbsh_ifs.sv
// Valid/ready channel interfaces for message bytes and digest words.
interface sbsh_msg_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] data_byte;

	modport source (output valid, output mode, output data_byte, input ready);
	modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface sbsh_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

>>> rtl/sbsh_datapath.sv
// Datapath: block buffer and message schedule window, round logic, hash words and bit count.
module sbsh_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        data_byte,
	input  sbsh_pkg::cmd_t    cmd,
	output sbsh_pkg::status_t status,
	output logic [31:0]       digest_word
);
	import sbsh_pkg::*;

	logic [31:0] h_q [0:7];
	logic [31:0] v_q [0:7];
	logic [31:0] w_q [0:15];
	logic [5:0]  fill_q;
	logic [63:0] bits_q;

	logic [7:0]  wr_byte;
	logic [7:0]  len_byte;
	logic [31:0] t1;
	logic [31:0] t2;
	logic [31:0] w_next;
	logic [31:0] ch;
	logic [31:0] maj;

	// The length goes out most significant byte first at buffer bytes 56 to 63.
	assign len_byte = bits_q[{~fill_q[2:0], 3'b000} +: 8];

	always_comb begin
		unique case (cmd.wr_src)
			SRC_DATA: wr_byte = data_byte;
			SRC_MARK: wr_byte = PAD_MARK;
			SRC_ZERO: wr_byte = 8'h00;
			SRC_LEN:  wr_byte = len_byte;
			default:  wr_byte = 8'h00;
		endcase
	end

	always_comb begin
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t1 = v_q[7] + big_sigma1(v_q[4]) + ch + ROUND_K[cmd.round_idx] + w_q[0];
		t2 = big_sigma0(v_q[0]) + maj;
		w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= HASH_IV[i];
			fill_q <= FILL_EMPTY;
			bits_q <= 64'd0;
		end else if (cmd.init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= HASH_IV[i];
			fill_q <= FILL_EMPTY;
			bits_q <= 64'd0;
		end else begin
			if (cmd.add_h) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end
			if (cmd.wr_en) fill_q <= fill_q + 6'd1;
			if (cmd.bits_inc) bits_q <= bits_q + 64'd8;
		end
	end

	// The sixteen buffer words double as the sliding schedule window during rounds.
	always_ff @(posedge clk) begin
		if (cmd.round_en) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i + 1];
			w_q[15] <= w_next;
		end else if (cmd.wr_en) begin
			unique case (fill_q[1:0])
				2'd0: w_q[fill_q[5:2]][31:24] <= wr_byte;
				2'd1: w_q[fill_q[5:2]][23:16] <= wr_byte;
				2'd2: w_q[fill_q[5:2]][15:8]  <= wr_byte;
				2'd3: w_q[fill_q[5:2]][7:0]   <= wr_byte;
				default: ;
			endcase
		end

		if (cmd.load_v) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round_en) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	assign status.fill = fill_q;
	assign digest_word = h_q[cmd.word_sel];

endmodule

>>> rtl/sbsh_ctrl.sv
// Controller: sequences absorb, padding, compression rounds and digest output.
module sbsh_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_mode,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        word_index,
	output logic              last_word,
	input  sbsh_pkg::status_t status,
	output sbsh_pkg::cmd_t    cmd
);
	import sbsh_pkg::*;

	state_t     state_q, state_d;
	state_t     ret_q, ret_d;
	logic       second_q, second_d;
	logic [5:0] rnd_q, rnd_d;
	logic [2:0] word_q, word_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ret_q    <= ST_IDLE;
			second_q <= 1'b0;
			rnd_q    <= 6'd0;
			word_q   <= 3'd0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			second_q <= second_d;
			rnd_q    <= rnd_d;
			word_q   <= word_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		second_d = second_q;
		rnd_d    = rnd_q;
		word_d   = word_q;
		cmd           = '0;
		cmd.wr_src    = SRC_DATA;
		cmd.round_idx = rnd_q;
		cmd.word_sel  = word_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.wr_en = 1'b1;
					if (in_mode == MODE_ABSORB) begin
						cmd.wr_src   = SRC_DATA;
						cmd.bits_inc = 1'b1;
						if (status.fill == FILL_LAST) begin
							ret_d   = ST_IDLE;
							state_d = ST_LOAD;
						end
					end else begin
						cmd.wr_src = SRC_MARK;
						second_d   = 1'b0;
						state_d    = ST_PAD_ZERO;
					end
				end
			end
			ST_PAD_ZERO: begin
				priority if (status.fill == FILL_LEN) begin
					state_d = ST_PAD_LEN;
				end else if (status.fill == FILL_EMPTY && !second_q) begin
					// The block filled up before the length field: compress it, then pad a second one.
					second_d = 1'b1;
					ret_d    = ST_PAD_ZERO;
					state_d  = ST_LOAD;
				end else begin
					cmd.wr_en  = 1'b1;
					cmd.wr_src = SRC_ZERO;
				end
			end
			ST_PAD_LEN: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_src = SRC_LEN;
				if (status.fill == FILL_LAST) begin
					ret_d   = ST_EMIT;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				cmd.load_v = 1'b1;
				rnd_d      = 6'd0;
				state_d    = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round_en = 1'b1;
				rnd_d        = rnd_q + 6'd1;
				if (rnd_q == ROUND_LAST) state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_h = 1'b1;
				word_d    = 3'd0;
				state_d   = ret_q;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					word_d = word_q + 3'd1;
					if (word_q == WORD_LAST) begin
						cmd.init = 1'b1;
						state_d  = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign word_index = word_q;
	assign last_word  = (word_q == WORD_LAST);

endmodule

>>> rtl/sha256_byte_stream_hasher.sv
// SHA-256 hasher over a byte stream. The msg channel carries one transaction per item:
// mode absorb brings data_byte into the 64-byte block buffer, mode finish pads the
// message with the 0x80 marker, zeros and the 64-bit big-endian bit length and then
// sends the digest on the digest channel as eight transactions, word 0 (most
// significant) first, with last_word set on the eighth.
// An absorb transaction is written to the buffer as it is accepted; one that fills a
// block is followed by its compression (load, 64 rounds of the single round unit,
// final add), and no new byte is taken until that is done, so the round unit sets
// the sustained byte rate. A finish writes the marker as it is accepted, then one
// padding byte per cycle, with a pause before the length field and one more where
// the first of two padding blocks is found full, and compresses one or two blocks
// (each: load, 64 rounds, add). The first digest word is offered latest when the
// marker lands at byte 56.
// Items are handled one at a time: msg.ready is high only while the block is idle.
// When the receiver stalls, the digest word is held until digest.ready; msg stays
// blocked until the eighth word is taken, at which point the hash state returns to
// the initial values and the bit count to zero.
// Reset is asynchronous and active low; it loads the initial hash values and clears
// the fill and bit counts. The buffer itself is not cleared, since padding rewrites
// every byte that a compression reads.
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher (
	input logic            clk,
	input logic            arst_n,
	sbsh_msg_if.sink       msg,
	sbsh_digest_if.source  digest
);
	import sbsh_pkg::*;

	cmd_t    cmd;
	status_t status;

	// Handshake events watched by the assertions below.
	logic finish_fire;
	logic last_fire;

	sbsh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (msg.valid),
		.in_mode    (msg.mode),
		.in_ready   (msg.ready),
		.out_valid  (digest.valid),
		.out_ready  (digest.ready),
		.word_index (digest.word_index),
		.last_word  (digest.last_word),
		.status     (status),
		.cmd        (cmd)
	);

	sbsh_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (msg.data_byte),
		.cmd         (cmd),
		.status      (status),
		.digest_word (digest.digest_word)
	);

	assign finish_fire = msg.valid && msg.ready && (msg.mode == MODE_FINISH);
	assign last_fire   = digest.valid && digest.ready && digest.last_word;

	// Input and output sides are never open at the same time.
	`SBSH_ASSERT_ALWAYS(a_no_overlap, !(msg.ready && digest.valid), "ready while digest valid")
	// A finish transaction closes the input side on the next cycle.
	`SBSH_ASSERT_NEXT(a_finish_blocks, finish_fire, !msg.ready, "input open after finish")
	// Taking the last digest word reopens the input and ends the digest run.
	`SBSH_ASSERT_NEXT(a_last_reopens, last_fire, msg.ready && !digest.valid, "no idle after last word")

endmodule

>>> dv/tb.sv
// Self-checking testbench for the SHA-256 byte stream hasher: directed and random messages, bit-exact digests.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sbsh_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 9;
	// The limit is several times the slowest correct run: under 900 transactions, each at
	// worst a finish with two padding blocks plus the longest sender gap and the longest
	// receiver gap on each of its eight words, and two long holds.
	localparam int TIMEOUT_CYCLES = 2000000;
	// Settle time, longer than a finish with two padding blocks needs before its first word.
	localparam int SETTLE_CYCLES = 250;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 235;

	// Round constants and initial chaining value of the standard, kept here on
	// purpose so that a wrong table inside the design cannot mask itself.
	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct {
		logic       mode;
		logic [7:0] data_byte;
	} msg_item_t;

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_item_t;

	logic clk;
	logic arst_n;

	sbsh_msg_if    msg_ch ();
	sbsh_digest_if digest_ch ();

	sha256_byte_stream_hasher DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (digest_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Stimulus waiting for the driver, and digest words that the hasher still owes.
	msg_item_t    pending_msgs[$];
	digest_item_t digest_words_due[$];

	// Shadow hash state, updated once for every accepted msg transaction.
	logic [31:0] chain_h [8];
	logic [7:0]  blk [64];
	logic [5:0]  blk_fill;
	logic [63:0] msg_bits;

	int queued_items;
	int accepted_items;
	int messages_done;
	int words_checked;
	int mismatch_count;
	int hold_requests;
	int holds_started;
	int receiver_hold_left;

	function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One 64-round compression of blk into chain_h.
	function automatic void compress_blk();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h;
		logic [31:0] x, y, t1, t2;
		int r;
		for (r = 0; r < 16; r++)
			w[r] = {blk[4 * r], blk[4 * r + 1], blk[4 * r + 2], blk[4 * r + 3]};
		for (r = 16; r < 64; r++) begin
			x = w[r - 15];
			y = w[r - 2];
			w[r] = (rotr32(y, 17) ^ rotr32(y, 19) ^ (y >> 10)) + w[r - 7] +
				(rotr32(x, 7) ^ rotr32(x, 18) ^ (x >> 3)) + w[r - 16];
		end
		a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
		e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
		for (r = 0; r < 64; r++) begin
			t1 = h + (rotr32(e, 6) ^ rotr32(e, 11) ^ rotr32(e, 25)) + ((e & f) ^ (~e & g)) +
				SHA_K[r] + w[r];
			t2 = (rotr32(a, 2) ^ rotr32(a, 13) ^ rotr32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
		chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
	endfunction

	// Back to the initial chaining value with an empty message. The buffer is
	// left alone, since padding rewrites every byte that a compression reads.
	function automatic void restart_sha_chain();
		int i;
		for (i = 0; i < 8; i++)
			chain_h[i] = SHA_IV[i];
		blk_fill = FILL_EMPTY;
		msg_bits = '0;
	endfunction

	// Applies one accepted transaction to the shadow state. A finish pads the
	// message (one final block, or two when fewer than nine bytes are free) and
	// queues the eight digest words, most significant first.
	function automatic void absorb_or_finish(input msg_item_t it);
		digest_item_t dw;
		int pos;
		int i;
		if (it.mode == MODE_ABSORB) begin
			blk[blk_fill] = it.data_byte;
			msg_bits += 64'd8;
			if (blk_fill == FILL_LAST) begin
				compress_blk();
				blk_fill = FILL_EMPTY;
			end else begin
				blk_fill++;
			end
		end else begin
			pos = blk_fill;
			blk[pos] = PAD_MARK;
			pos++;
			if (pos > 56) begin
				for (i = pos; i < 64; i++)
					blk[i] = 8'h00;
				compress_blk();
				for (i = 0; i < 56; i++)
					blk[i] = 8'h00;
			end else begin
				for (i = pos; i < 56; i++)
					blk[i] = 8'h00;
			end
			for (i = 0; i < 8; i++)
				blk[56 + i] = msg_bits[63 - 8 * i -: 8];
			compress_blk();
			for (i = 0; i < 8; i++) begin
				dw.digest_word = chain_h[i];
				dw.word_index = 3'(i);
				dw.last_word = (3'(i) == WORD_LAST);
				digest_words_due.push_back(dw);
			end
			messages_done++;
			restart_sha_chain();
		end
	endfunction

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 55)
			return 0;
		if (sel < 90)
			return $urandom_range(1, 3);
		if (sel < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// Message bytes lean toward the all-zero, all-one and marker patterns.
	function automatic logic [7:0] random_byte();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 8'h00;
		if (sel == 1)
			return 8'hff;
		if (sel == 2)
			return PAD_MARK;
		return 8'($urandom_range(0, 255));
	endfunction

	// Most messages are short; block and padding boundaries get extra weight,
	// and only a few messages run over three blocks.
	function automatic int pick_len();
		int sel;
		int edges [12] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};
		sel = $urandom_range(0, 99);
		if (sel < 45)
			return $urandom_range(0, 20);
		if (sel < 70)
			return edges[$urandom_range(0, 11)];
		if (sel < 92)
			return $urandom_range(21, 130);
		return $urandom_range(131, 200);
	endfunction

	task automatic push_item(input logic mode, input logic [7:0] data_byte);
		msg_item_t it;
		it.mode = mode;
		it.data_byte = data_byte;
		pending_msgs.push_back(it);
		queued_items++;
	endtask

	// A whole message: len random bytes and then a finish whose byte is junk.
	task automatic queue_message(input int len);
		int i;
		for (i = 0; i < len; i++)
			push_item(MODE_ABSORB, random_byte());
		push_item(MODE_FINISH, 8'($urandom_range(0, 255)));
	endtask

	// Random messages until the phase has its share of transactions. One in ten
	// picks is a bare finish, which hashes the empty message right after another.
	task automatic queue_random_phase(input int count);
		int target;
		target = queued_items + count;
		while (queued_items < target) begin
			if ($urandom_range(0, 9) == 0)
				push_item(MODE_FINISH, 8'($urandom_range(0, 255)));
			else
				queue_message(pick_len());
		end
	endtask

	// The sender holds back here until every transaction is in and every digest
	// word it caused has been checked.
	task automatic wait_drained();
		while (accepted_items != queued_items || digest_words_due.size() != 0)
			@(posedge clk);
	endtask

	// Driver. A transaction completes at an edge with valid and ready both high;
	// only then is it handed to the shadow model and the next one offered, after
	// a random gap. Valid stays high across back-to-back transactions.
	msg_item_t in_flight;
	int tx_gap;

	always @(posedge clk) begin
		if (!arst_n) begin
			msg_ch.valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (msg_ch.valid && msg_ch.ready) begin
				absorb_or_finish(in_flight);
				accepted_items++;
			end
			if (!msg_ch.valid || msg_ch.ready) begin
				if (tx_gap > 0) begin
					tx_gap--;
					msg_ch.valid <= 1'b0;
				end else if (pending_msgs.size() != 0) begin
					in_flight = pending_msgs.pop_front();
					msg_ch.valid <= 1'b1;
					msg_ch.mode <= in_flight.mode;
					msg_ch.data_byte <= in_flight.data_byte;
					tx_gap = pick_gap();
				end else begin
					msg_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold. Each request from the stimulus starts a hold at the
	// first digest word that shows up afterwards, so the hasher sits on a full
	// digest while the driver keeps offering the next message.
	always @(posedge clk) begin
		if (!arst_n) begin
			receiver_hold_left <= 0;
		end else if (holds_started < hold_requests && digest_ch.valid) begin
			receiver_hold_left <= LONG_HOLD_CYCLES;
			holds_started <= holds_started + 1;
		end else if (receiver_hold_left > 0) begin
			receiver_hold_left <= receiver_hold_left - 1;
		end
	end

	// Monitor. Every digest transaction is checked field by field against the
	// oldest word still owed; ready drops at random and during a long hold.
	int rx_gap;

	always @(posedge clk) begin
		digest_item_t want;
		if (!arst_n) begin
			digest_ch.ready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (digest_ch.valid && digest_ch.ready) begin
				if (digest_words_due.size() == 0) begin
					$display("%0t: digest word %h (index %0d) arrived with none expected",
						$time, digest_ch.digest_word, digest_ch.word_index);
					mismatch_count++;
				end else begin
					want = digest_words_due.pop_front();
					words_checked++;
					if (digest_ch.digest_word !== want.digest_word) begin
						$display("%0t: digest_word expected %h, got %h", $time,
							want.digest_word, digest_ch.digest_word);
						mismatch_count++;
					end
					if (digest_ch.word_index !== want.word_index) begin
						$display("%0t: word_index expected %0d, got %0d", $time,
							want.word_index, digest_ch.word_index);
						mismatch_count++;
					end
					if (digest_ch.last_word !== want.last_word) begin
						$display("%0t: last_word expected %b, got %b", $time,
							want.last_word, digest_ch.last_word);
						mismatch_count++;
					end
				end
			end
			if (receiver_hold_left > 0) begin
				digest_ch.ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap--;
				digest_ch.ready <= 1'b0;
			end else begin
				digest_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					rx_gap = pick_gap();
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * CLK_PERIOD);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		msg_ch.valid = 1'b0;
		msg_ch.mode = MODE_ABSORB;
		msg_ch.data_byte = 8'h00;
		digest_ch.ready = 1'b0;
		queued_items = 0;
		accepted_items = 0;
		messages_done = 0;
		words_checked = 0;
		mismatch_count = 0;
		hold_requests = 0;
		holds_started = 0;
		restart_sha_chain();

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: the empty message straight out of reset, the classic "abc",
		// the extreme bytes, an empty message whose finish carries a junk byte,
		// and a lone marker-valued byte that must not be taken for padding.
		push_item(MODE_FINISH, 8'h00);
		push_item(MODE_ABSORB, 8'h61);
		push_item(MODE_ABSORB, 8'h62);
		push_item(MODE_ABSORB, 8'h63);
		push_item(MODE_FINISH, 8'hff);
		push_item(MODE_ABSORB, 8'h00);
		push_item(MODE_ABSORB, 8'hff);
		push_item(MODE_FINISH, 8'h00);
		push_item(MODE_FINISH, 8'hff);
		push_item(MODE_ABSORB, PAD_MARK);
		push_item(MODE_FINISH, 8'h5a);
		wait_drained();

		// Two random phases, each opening with a long receiver hold and closed
		// by a full drain on the sender side.
		hold_requests++;
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		hold_requests++;
		queue_random_phase(PHASE_ITEMS);
		wait_drained();

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Hashed %0d messages over %0d transactions and checked %0d digest words.",
			messages_done, accepted_items, words_checked);
		$display("Covered empty, one- and two-block padding, %0d long receiver holds.",
			holds_started);
		if (mismatch_count == 0 && digest_words_due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
